// File: rtl/core/krst_pkg.sv
// Shared types and codes for the keyed read statistics table.
package krst_pkg;

    // Command codes
    localparam logic [1:0] CMD_RECORD = 2'd0;
    localparam logic [1:0] CMD_EXPIRE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_UPDATED  = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_SWEPT    = 3'd3;
    localparam logic [2:0] ST_READ_OK  = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;

    // Register map
    localparam logic REG_EXPIRE_MINUTES = 1'b0;
    localparam logic [15:0] EXPIRE_MINUTES_RST = 16'd45000;

    // Full key; field order gives the sort order when compared as one vector
    typedef struct packed {
        logic [14:0] class_volid;
        logic [30:0] class_pageid;
        logic [14:0] class_slotid;
        logic [14:0] index_volid;
        logic [30:0] index_fileid;
    } t_key;

    // One table entry: key and statistics
    typedef struct packed {
        t_key        key;
        logic [31:0] hits;
        logic [30:0] last_pages;
        logic [31:0] last_time;
        logic [30:0] peak_pages;
        logic [31:0] peak_time;
    } t_entry;

endpackage

// File: rtl/core/krst_ram.sv
// Entry memory: one write port, one read port with registered read data.
module krst_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  krst_pkg::t_entry  i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output krst_pkg::t_entry  o_rdata
);

    krst_pkg::t_entry r_mem [DEPTH];
    krst_pkg::t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/krst_seq.sv
// Command sequencer: search, shift-insert, sweep and read over the entry memory.
module krst_seq #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int CW    = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [1:0]        i_cmd,
    input  krst_pkg::t_key    i_key,
    input  logic [31:0]       i_now_time,
    input  logic [30:0]       i_npages,
    input  logic [5:0]        i_rank,
    input  logic [15:0]       i_expire_minutes,
    output logic              o_valid,
    output logic [2:0]        o_status,
    output krst_pkg::t_entry  o_entry,
    output logic [6:0]        o_count,
    output logic              o_ram_we,
    output logic [AW-1:0]     o_ram_waddr,
    output krst_pkg::t_entry  o_ram_wdata,
    output logic [AW-1:0]     o_ram_raddr,
    input  krst_pkg::t_entry  i_ram_rdata
);

    localparam int CMPW = (CW > 6) ? CW : 6;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SRCH  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_INS   = 3'd3;
    localparam logic [2:0] S_EXP   = 3'd4;
    localparam logic [2:0] S_RD    = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_ptr, n_ptr;
    krst_pkg::t_key    r_key, n_key;
    logic [31:0]       r_now, n_now;
    logic [30:0]       r_np, n_np;
    logic              r_valid, n_valid;
    logic [2:0]        r_status, n_status;
    krst_pkg::t_entry  r_out, n_out;
    logic [6:0]        r_ocnt, n_ocnt;

    logic [21:0]       dur;
    logic              keep;
    logic              key_eq;
    logic              key_gt;
    logic [CW-1:0]     idx_nxt;
    logic              start_ok;
    krst_pkg::t_entry  upd;
    krst_pkg::t_entry  ins;
    krst_pkg::t_entry  full_res;

    assign start_ok = i_start && (r_state == S_IDLE);
    assign o_busy   = (r_state != S_IDLE);

    // duration in seconds: minutes * 60
    assign dur  = {i_expire_minutes, 6'b0} - {4'b0, i_expire_minutes, 2'b0};
    assign keep = ({1'b0, i_ram_rdata.last_time} + 33'(dur)) >= {1'b0, r_now};

    // key compare of the entry just read
    assign key_eq  = (i_ram_rdata.key == r_key);
    assign key_gt  = (i_ram_rdata.key > r_key);
    assign idx_nxt = r_idx + CW'(1);

    // updated entry on a hit
    always_comb begin
        upd            = i_ram_rdata;
        upd.last_time  = r_now;
        upd.last_pages = r_np;
        if (i_ram_rdata.peak_pages <= r_np) begin
            upd.peak_pages = r_np;
            upd.peak_time  = r_now;
        end
        if (i_ram_rdata.hits != 32'hFFFF_FFFF) begin
            upd.hits = i_ram_rdata.hits + 32'd1;
        end
    end

    // fresh entry on insert
    always_comb begin
        ins            = '0;
        ins.key        = r_key;
        ins.hits       = 32'd1;
        ins.last_pages = r_np;
        ins.last_time  = r_now;
        ins.peak_pages = r_np;
        ins.peak_time  = r_now;
    end

    // table full: key echoed, statistics zero
    always_comb begin
        full_res     = '0;
        full_res.key = r_key;
    end

    // next state logic
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_ptr       = r_ptr;
        n_key       = r_key;
        n_now       = r_now;
        n_np        = r_np;
        n_valid     = 1'b0;
        n_status    = r_status;
        n_out       = r_out;
        n_ocnt      = r_ocnt;
        o_ram_we    = 1'b0;
        o_ram_waddr = '0;
        o_ram_wdata = i_ram_rdata;
        o_ram_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start_ok) begin
                    n_key = i_key;
                    n_now = i_now_time;
                    n_np  = i_npages;
                    n_idx = '0;
                    n_ptr = '0;
                    priority if (i_cmd == krst_pkg::CMD_RECORD) begin
                        // empty table inserts at once
                        n_state = (r_cnt == '0) ? S_INS : S_SRCH;
                    end else if (i_cmd == krst_pkg::CMD_EXPIRE) begin
                        if (r_cnt == '0) begin
                            n_valid  = 1'b1;
                            n_status = krst_pkg::ST_SWEPT;
                            n_out    = '0;
                            n_ocnt   = 7'(r_cnt);
                        end else begin
                            n_state = S_EXP;
                        end
                    end else if (i_cmd == krst_pkg::CMD_READ &&
                                 CMPW'(i_rank) < CMPW'(r_cnt)) begin
                        o_ram_raddr = AW'(i_rank);
                        n_state     = S_RD;
                    end else begin
                        n_valid  = 1'b1;
                        n_status = krst_pkg::ST_EMPTY;
                        n_out    = '0;
                        n_ocnt   = 7'(r_cnt);
                    end
                end
            end

            S_SRCH: begin
                if (key_eq) begin
                    // hit: write back updated statistics
                    o_ram_we    = 1'b1;
                    o_ram_waddr = r_idx[AW-1:0];
                    o_ram_wdata = upd;
                    n_valid     = 1'b1;
                    n_status    = krst_pkg::ST_UPDATED;
                    n_out       = upd;
                    n_ocnt      = 7'(r_cnt);
                    n_state     = S_IDLE;
                end else if (key_gt || idx_nxt == r_cnt) begin
                    // miss: insertion point found
                    n_idx = key_gt ? r_idx : idx_nxt;
                    if (r_cnt == CW'(DEPTH)) begin
                        n_valid  = 1'b1;
                        n_status = krst_pkg::ST_FULL;
                        n_out    = full_res;
                        n_ocnt   = 7'(r_cnt);
                        n_state  = S_IDLE;
                    end else if (n_idx == r_cnt) begin
                        n_state = S_INS;
                    end else begin
                        o_ram_raddr = AW'(r_cnt - CW'(1));
                        n_ptr       = r_cnt;
                        n_state     = S_SHIFT;
                    end
                end else begin
                    o_ram_raddr = idx_nxt[AW-1:0];
                    n_idx       = idx_nxt;
                end
            end

            S_SHIFT: begin
                // move entry ptr-1 up to ptr, fetch the next one down
                o_ram_we    = 1'b1;
                o_ram_waddr = r_ptr[AW-1:0];
                o_ram_wdata = i_ram_rdata;
                n_ptr       = r_ptr - CW'(1);
                if (n_ptr > r_idx) begin
                    o_ram_raddr = AW'(r_ptr - CW'(2));
                end else begin
                    n_state = S_INS;
                end
            end

            S_INS: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_idx[AW-1:0];
                o_ram_wdata = ins;
                n_cnt       = r_cnt + CW'(1);
                n_valid     = 1'b1;
                n_status    = krst_pkg::ST_INSERTED;
                n_out       = ins;
                n_ocnt      = 7'(n_cnt);
                n_state     = S_IDLE;
            end

            S_EXP: begin
                // compact kept entries down to the write pointer
                if (keep) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = r_ptr[AW-1:0];
                    o_ram_wdata = i_ram_rdata;
                    n_ptr       = r_ptr + CW'(1);
                end
                if (idx_nxt == r_cnt) begin
                    n_cnt    = n_ptr;
                    n_valid  = 1'b1;
                    n_status = krst_pkg::ST_SWEPT;
                    n_out    = '0;
                    n_ocnt   = 7'(n_ptr);
                    n_state  = S_IDLE;
                end else begin
                    o_ram_raddr = idx_nxt[AW-1:0];
                    n_idx       = idx_nxt;
                end
            end

            S_RD: begin
                n_valid  = 1'b1;
                n_status = krst_pkg::ST_READ_OK;
                n_out    = i_ram_rdata;
                n_ocnt   = 7'(r_cnt);
                n_state  = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_ptr    <= n_ptr;
        r_key    <= n_key;
        r_now    <= n_now;
        r_np     <= n_np;
        r_status <= n_status;
        r_out    <= n_out;
        r_ocnt   <= n_ocnt;
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_entry  = r_out;
    assign o_count  = r_ocnt;

endmodule

// File: rtl/core/keyed_read_stats_table_top.sv
// Top level of the keyed read statistics table: register port, sequencer, memory.
//
// Usage: drive a request on the i_ input fields with start high while busy is
// low; the request is taken at that edge and busy rises, unless the request is
// answered from idle. Exactly one result follows, shown for a single cycle with
// o_valid high; the receiver cannot stall it, so it must take it in that cycle.
// Steps (p = insertion rank, h = hit rank): read at rank: one memory read;
//   empty rank, unused command or expire of an empty table: answered from
//   idle; record hit: search reads up to rank h, then the write-back; record
//   insert: search reads up to rank p, a shift of the entries from p up and
//   one write; expire: one entry read and compacted per cycle, all entries.
// All of this is set by the single read port of the entry memory, which is
// walked one entry per cycle. The next request may start in the cycle the
// result is shown.
// expire_minutes sits at byte address 0 of the APB port (reset 45000);
// write it only while busy is low. Reset empties the table at once; memory
// contents need no clearing, since only entries below the count are read.
module keyed_read_stats_table_top #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [14:0] i_class_volid,
    input  logic [30:0] i_class_pageid,
    input  logic [14:0] i_class_slotid,
    input  logic [14:0] i_index_volid,
    input  logic [30:0] i_index_fileid,
    input  logic [31:0] i_now_time,
    input  logic [30:0] i_npages,
    input  logic [5:0]  i_rank,
    // result channel
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [14:0] o_out_class_volid,
    output logic [30:0] o_out_class_pageid,
    output logic [14:0] o_out_class_slotid,
    output logic [14:0] o_out_index_volid,
    output logic [30:0] o_out_index_fileid,
    output logic [31:0] o_hit_count,
    output logic [30:0] o_recent_pages,
    output logic [31:0] o_recent_time,
    output logic [30:0] o_max_pages,
    output logic [31:0] o_max_time,
    output logic [6:0]  o_entry_count,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [15:0]       r_expire_minutes;
    logic              cfg_wr;
    krst_pkg::t_key    in_key;
    krst_pkg::t_entry  res;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    krst_pkg::t_entry  ram_wdata;
    logic [AW-1:0]     ram_raddr;
    krst_pkg::t_entry  ram_rdata;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[2] == krst_pkg::REG_EXPIRE_MINUTES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expire_minutes <= krst_pkg::EXPIRE_MINUTES_RST;
        end else if (cfg_wr) begin
            r_expire_minutes <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == krst_pkg::REG_EXPIRE_MINUTES) ?
                    {16'b0, r_expire_minutes} : 32'b0;

    // request key
    assign in_key.class_volid  = i_class_volid;
    assign in_key.class_pageid = i_class_pageid;
    assign in_key.class_slotid = i_class_slotid;
    assign in_key.index_volid  = i_index_volid;
    assign in_key.index_fileid = i_index_fileid;

    krst_seq #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .o_busy           (busy),
        .i_cmd            (i_cmd),
        .i_key            (in_key),
        .i_now_time       (i_now_time),
        .i_npages         (i_npages),
        .i_rank           (i_rank),
        .i_expire_minutes (r_expire_minutes),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_entry          (res),
        .o_count          (o_entry_count),
        .o_ram_we         (ram_we),
        .o_ram_waddr      (ram_waddr),
        .o_ram_wdata      (ram_wdata),
        .o_ram_raddr      (ram_raddr),
        .i_ram_rdata      (ram_rdata)
    );

    krst_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // result fields
    assign o_out_class_volid  = res.key.class_volid;
    assign o_out_class_pageid = res.key.class_pageid;
    assign o_out_class_slotid = res.key.class_slotid;
    assign o_out_index_volid  = res.key.index_volid;
    assign o_out_index_fileid = res.key.index_fileid;
    assign o_hit_count        = res.hits;
    assign o_recent_pages     = res.last_pages;
    assign o_recent_time      = res.last_time;
    assign o_max_pages        = res.peak_pages;
    assign o_max_time         = res.peak_time;

    // a result is only shown once the sequencer is back to idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    // a freshly inserted entry has one hit and equal recent and peak stats
    a_insert_stats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == krst_pkg::ST_INSERTED) |->
        (o_hit_count == 32'd1 && o_max_pages == o_recent_pages &&
         o_max_time == o_recent_time))
        else $error("inserted entry statistics wrong");

    // full is only reported with the table at capacity and zero statistics
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == krst_pkg::ST_FULL) |->
        (o_entry_count == 7'(TABLE_DEPTH) && o_hit_count == 32'd0))
        else $error("full reported below capacity");

    // a hit never leaves the peak below the recent page count, nor the hit count at zero
    a_hit_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == krst_pkg::ST_UPDATED) |->
        (o_max_pages >= o_recent_pages && o_hit_count != 32'd0))
        else $error("updated entry peak below recent");

endmodule
